[rtl/dkl_pkg.sv]
// Shared types and constants for the double-ended queue with key lookup.
package dkl_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT    = 4'd0,
    CMD_PUSH_BACK     = 4'd1,
    CMD_PEEK_FRONT    = 4'd2,
    CMD_PEEK_BACK     = 4'd3,
    CMD_LOOKUP        = 4'd4,
    CMD_REMOVE_HANDLE = 4'd5,
    CMD_POP_FRONT     = 4'd6,
    CMD_POP_BACK      = 4'd7,
    CMD_CLEAR         = 4'd8
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SHIFT_IN,
    OP_LOAD_AT,
    OP_FIRST,
    OP_LAST,
    OP_SEARCH_KEY,
    OP_SEARCH_HANDLE
  } op_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [7:0]  kind;
    logic [31:0] cookie;
  } entry_t;

  typedef struct packed {
    logic             en;
    op_t              op;
    logic             remove;
    logic [OCC_W-1:0] occ;
    entry_t           key;
  } cell_ctrl_t;

endpackage

[rtl/dkl_cell.sv]
// One queue slot: holds an entry, compares it and shifts it with its neighbours.
module dkl_cell (
  input  logic                    clk,
  input  dkl_pkg::cell_ctrl_t     ctrl,
  input  logic [dkl_pkg::IDX_W-1:0] idx,
  input  dkl_pkg::entry_t         left_ent,
  input  dkl_pkg::entry_t         right_ent,
  input  logic                    hit_in,
  input  dkl_pkg::entry_t         sel_in,
  output dkl_pkg::entry_t         ent,
  output logic                    hit_out,
  output dkl_pkg::entry_t         sel_out
);

  dkl_pkg::entry_t ent_r;
  dkl_pkg::entry_t ent_nxt;
  logic [dkl_pkg::OCC_W-1:0] pos;
  logic live;
  logic is_tail;
  logic sel_self;

  assign pos     = dkl_pkg::OCC_W'(idx);
  assign live    = pos < ctrl.occ;
  assign is_tail = (pos + dkl_pkg::OCC_W'(1)) == ctrl.occ;

  always_comb begin
    case (ctrl.op)
      dkl_pkg::OP_FIRST:      sel_self = live && (pos == '0);
      dkl_pkg::OP_LAST:       sel_self = live && is_tail;
      dkl_pkg::OP_SEARCH_KEY: sel_self = live && !hit_in &&
                                         (ent_r.kind == ctrl.key.kind) &&
                                         (ent_r.cookie == ctrl.key.cookie);
      dkl_pkg::OP_SEARCH_HANDLE: sel_self = live && !hit_in &&
                                            (ent_r.handle == ctrl.key.handle);
      default:                sel_self = 1'b0;
    endcase
  end

  assign hit_out = hit_in | sel_self;
  assign sel_out = sel_self ? ent_r : sel_in;
  assign ent     = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.en) begin
      case (ctrl.op)
        dkl_pkg::OP_SHIFT_IN: ent_nxt = left_ent;
        dkl_pkg::OP_LOAD_AT: begin
          if (pos == ctrl.occ) ent_nxt = ctrl.key;
        end
        default: begin
          if (ctrl.remove && hit_out) ent_nxt = right_ent;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

[rtl/deque_with_key_lookup_unit.sv]
// Top level of the double-ended queue with key lookup.
// The queue holds up to DEPTH entries of handle, kind and cookie, head in
// slot 0, in a row of cells that shift towards the head or the tail.
// Commands arrive on the in_ channel and each yields exactly one result
// transaction on the out_ channel with a status, the entry concerned and
// the entry count after the command.
// Every command, searches included, is done in the cycle it is accepted:
// each cell compares its own entry and a first-match chain runs along the
// row, so the result is in the output register in the following cycle.
// Throughput is one transaction per cycle while out_ready is high.
// When the receiver stalls, the result holds in the output register and a
// new command is accepted in the same cycle the result is taken.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared and need not be, as only occupied slots are ever read.
module deque_with_key_lookup_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic [15:0] in_handle,
  input  logic [7:0]  in_entry_kind,
  input  logic [31:0] in_cookie,
  input  logic        in_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_handle_out,
  output logic [7:0]  out_kind_out,
  output logic [31:0] out_cookie_out,
  output logic [4:0]  out_count
);

  localparam int N = dkl_pkg::DEPTH;

  logic accept;
  logic [dkl_pkg::OCC_W-1:0] occ_r, occ_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;
  dkl_pkg::entry_t res_r;
  logic [dkl_pkg::COUNT_W-1:0] count_r;
  logic full;
  logic found;
  dkl_pkg::cell_ctrl_t ctrl;
  dkl_pkg::entry_t cell_ent [N];
  logic hit_chain [N+1];
  dkl_pkg::entry_t sel_chain [N+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = occ_r == dkl_pkg::OCC_W'(N);

  always_comb begin
    ctrl.en         = accept;
    ctrl.op         = dkl_pkg::OP_NONE;
    ctrl.remove     = 1'b0;
    ctrl.occ        = occ_r;
    ctrl.key.handle = in_handle;
    ctrl.key.kind   = in_entry_kind;
    ctrl.key.cookie = in_cookie;
    case (dkl_pkg::cmd_t'(in_cmd))
      dkl_pkg::CMD_PUSH_FRONT: if (!full) ctrl.op = dkl_pkg::OP_SHIFT_IN;
      dkl_pkg::CMD_PUSH_BACK:  if (!full) ctrl.op = dkl_pkg::OP_LOAD_AT;
      dkl_pkg::CMD_PEEK_FRONT: ctrl.op = dkl_pkg::OP_FIRST;
      dkl_pkg::CMD_PEEK_BACK:  ctrl.op = dkl_pkg::OP_LAST;
      dkl_pkg::CMD_POP_FRONT: begin
        ctrl.op     = dkl_pkg::OP_FIRST;
        ctrl.remove = 1'b1;
      end
      dkl_pkg::CMD_POP_BACK: begin
        ctrl.op     = dkl_pkg::OP_LAST;
        ctrl.remove = 1'b1;
      end
      dkl_pkg::CMD_LOOKUP: begin
        ctrl.op     = dkl_pkg::OP_SEARCH_KEY;
        ctrl.remove = in_take;
      end
      dkl_pkg::CMD_REMOVE_HANDLE: begin
        ctrl.op     = dkl_pkg::OP_SEARCH_HANDLE;
        ctrl.remove = 1'b1;
      end
      default: ctrl.op = dkl_pkg::OP_NONE;
    endcase
  end

  assign hit_chain[0] = 1'b0;
  assign sel_chain[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    dkl_pkg::entry_t left_ent;
    dkl_pkg::entry_t right_ent;
    if (g == 0) begin : g_head
      assign left_ent = ctrl.key;
    end else begin : g_mid
      assign left_ent = cell_ent[g-1];
    end
    if (g == N - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = cell_ent[g+1];
    end
    dkl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (dkl_pkg::IDX_W'(g)),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .hit_in    (hit_chain[g]),
      .sel_in    (sel_chain[g]),
      .ent       (cell_ent[g]),
      .hit_out   (hit_chain[g+1]),
      .sel_out   (sel_chain[g+1])
    );
  end

  assign found = hit_chain[N];

  always_comb begin
    occ_nxt    = occ_r;
    status_nxt = dkl_pkg::ST_OK;
    case (dkl_pkg::cmd_t'(in_cmd))
      dkl_pkg::CMD_PUSH_FRONT, dkl_pkg::CMD_PUSH_BACK: begin
        if (full) status_nxt = dkl_pkg::ST_FULL;
        else occ_nxt = occ_r + dkl_pkg::OCC_W'(1);
      end
      dkl_pkg::CMD_PEEK_FRONT, dkl_pkg::CMD_PEEK_BACK, dkl_pkg::CMD_POP_FRONT,
      dkl_pkg::CMD_POP_BACK, dkl_pkg::CMD_LOOKUP, dkl_pkg::CMD_REMOVE_HANDLE: begin
        if (!found) status_nxt = dkl_pkg::ST_NONE;
        else if (ctrl.remove) occ_nxt = occ_r - dkl_pkg::OCC_W'(1);
      end
      dkl_pkg::CMD_CLEAR: occ_nxt = '0;
      default: occ_nxt = occ_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      res_r    <= sel_chain[N];
      count_r  <= dkl_pkg::COUNT_W'(occ_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_handle_out = res_r.handle;
  assign out_kind_out   = res_r.kind;
  assign out_cookie_out = res_r.cookie;
  assign out_count      = count_r;

endmodule

[rtl/dkl_checker.sv]
// Port-level checks for the double-ended queue with key lookup.
module dkl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_handle_out,
  input logic [7:0]  out_kind_out,
  input logic [31:0] out_cookie_out,
  input logic [4:0]  out_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result transaction dropped while stalled.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dkl_pkg::ST_FULL) |->
      (out_count == 5'(dkl_pkg::DEPTH)))
    else $error("Full status reported below capacity.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= 5'(dkl_pkg::DEPTH)))
    else $error("Entry count exceeds capacity.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != dkl_pkg::ST_OK) |->
      (out_handle_out == '0) && (out_kind_out == '0) && (out_cookie_out == '0))
    else $error("Failed command returned entry data.");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind deque_with_key_lookup_unit dkl_checker u_dkl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_handle_out (out_handle_out),
  .out_kind_out   (out_kind_out),
  .out_cookie_out (out_cookie_out),
  .out_count      (out_count)
);
